// File: hw/rtl/swlr_pkg.sv
// Package for the sliding window linear regression unit: constants, types, helpers.
package swlr_pkg;

	localparam int unsigned WindowSize = 8;
	localparam int unsigned SlotW = (WindowSize > 1) ? $clog2(WindowSize) : 1;
	localparam int unsigned CountW = $clog2(WindowSize + 1);
	localparam logic signed [63:0] Scale = 64'sd1000;
	localparam int unsigned XW = 26;
	localparam int unsigned YW = 27;

	typedef logic signed [63:0] word_t;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		word_t   a;
		word_t   b;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		word_t res;
	} alu_rsp_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_MXY,
		ST_MXX,
		ST_OXY,
		ST_OXX,
		ST_F0,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_D0,
		ST_D1,
		ST_D2,
		ST_D3,
		ST_AVGXY,
		ST_AVGSQ,
		ST_CHK,
		ST_BZV,
		ST_BDIV,
		ST_BMX,
		ST_ADIV,
		ST_BQ,
		ST_OUT
	} state_t;

endpackage

// File: hw/rtl/swlr_ram.sv
// Generic single-port RAM with registered read.
module swlr_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: hw/rtl/swlr_alu.sv
// Shared iterative unit: 64-bit wrapping multiply (shift-add) and truncating divide.
module swlr_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  swlr_pkg::alu_req_t  req,
	output swlr_pkg::alu_rsp_t  rsp
);

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic        op_div_q;
	logic [63:0] acc_q;
	logic [63:0] mcand_q;
	logic [63:0] mplier_q;
	logic [63:0] rem_q;
	logic        neg_q;
	logic        fin_q;
	logic [63:0] res_q;
	logic [64:0] trial;
	logic [63:0] rem_sh;

	assign rem_sh = {rem_q[62:0], mplier_q[63]};
	assign trial = {1'b0, rem_sh} - {1'b0, mcand_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_div_q <= (req.op == swlr_pkg::OP_DIV);
			acc_q <= '0;
			rem_q <= '0;
			if (req.op == swlr_pkg::OP_DIV) begin
				mplier_q <= req.a[63] ? 64'(-req.a) : req.a;
				mcand_q <= req.b[63] ? 64'(-req.b) : req.b;
				neg_q <= req.a[63] ^ req.b[63];
			end else begin
				mplier_q <= req.b;
				mcand_q <= req.a;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (op_div_q) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					mplier_q <= {mplier_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					mplier_q <= {mplier_q[62:0], 1'b0};
				end
			end else begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[62:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[63:1]};
			end
		end
		if (fin_q) begin
			res_q <= op_div_q ? (neg_q ? 64'(-mplier_q) : mplier_q) : acc_q;
		end
	end

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule

// File: hw/rtl/sliding_window_linear_regression_unit.sv
// Each input transfer reaches out_valid through 11 to 16 operations on the shared unit
// (fewer once the window is full, fewest when the variance is zero).
// Throughput: one item at a time; in_ready is high only while idle with no result pending,
// so the next transfer is taken only after the result has been accepted.
// Reset (arst_n low, asynchronous) clears control, counters, means and coefficients; window
// storage is not cleared, its slots are read only after being written.
module sliding_window_linear_regression_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        sample_x,
	input  logic signed [15:0] sample_y,
	input  logic [15:0]        query_x,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] prediction,
	output logic signed [63:0] intercept,
	output logic signed [63:0] slope
);

	swlr_pkg::state_t state_q, state_d;
	swlr_pkg::alu_req_t req;
	swlr_pkg::alu_rsp_t rsp;

	logic [swlr_pkg::SlotW-1:0]  slot_q;
	logic [swlr_pkg::CountW-1:0] fill_q;
	swlr_pkg::word_t mx_q, my_q, mxy_q, mxx_q, a_q, b_q;
	swlr_pkg::word_t x_q, y_q, q_q, xy_q, xx_q, oxy_q, oxx_q, t_q, avxy_q, avsq_q;
	logic issued_q;
	logic full;
	logic [swlr_pkg::XW-1:0] ox_raw;
	logic [swlr_pkg::YW-1:0] oy_raw;
	swlr_pkg::word_t ox, oy, k;
	logic ram_we;

	assign full = (fill_q == swlr_pkg::CountW'(swlr_pkg::WindowSize));
	assign k = 64'(fill_q);
	assign ox = 64'(ox_raw);
	assign oy = 64'(signed'(oy_raw));
	assign ram_we = (state_q == swlr_pkg::ST_OUT) && !out_valid;

	swlr_ram #(.Width(swlr_pkg::XW), .Depth(swlr_pkg::WindowSize)) u_ram_x (
		.clk(clk), .we(ram_we), .addr(slot_q),
		.wdata(x_q[swlr_pkg::XW-1:0]), .rdata(ox_raw)
	);
	swlr_ram #(.Width(swlr_pkg::YW), .Depth(swlr_pkg::WindowSize)) u_ram_y (
		.clk(clk), .we(ram_we), .addr(slot_q),
		.wdata(y_q[swlr_pkg::YW-1:0]), .rdata(oy_raw)
	);

	swlr_alu u_alu (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign in_ready = (state_q == swlr_pkg::ST_IDLE) && !out_valid;

	// next state; while filling, each product with k is followed by its division
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swlr_pkg::ST_IDLE: if (in_valid && in_ready) state_d = swlr_pkg::ST_MXY;
			swlr_pkg::ST_MXY:  if (rsp.done) state_d = swlr_pkg::ST_MXX;
			swlr_pkg::ST_MXX:  if (rsp.done) state_d = full ? swlr_pkg::ST_OXY : swlr_pkg::ST_F0;
			swlr_pkg::ST_OXY:  if (rsp.done) state_d = swlr_pkg::ST_OXX;
			swlr_pkg::ST_OXX:  if (rsp.done) state_d = swlr_pkg::ST_D0;
			swlr_pkg::ST_F0:   if (rsp.done) state_d = swlr_pkg::ST_D0;
			swlr_pkg::ST_F1:   if (rsp.done) state_d = swlr_pkg::ST_D1;
			swlr_pkg::ST_F2:   if (rsp.done) state_d = swlr_pkg::ST_D2;
			swlr_pkg::ST_F3:   if (rsp.done) state_d = swlr_pkg::ST_D3;
			swlr_pkg::ST_D0:   if (rsp.done) state_d = full ? swlr_pkg::ST_D1 : swlr_pkg::ST_F1;
			swlr_pkg::ST_D1:   if (rsp.done) state_d = full ? swlr_pkg::ST_D2 : swlr_pkg::ST_F2;
			swlr_pkg::ST_D2:   if (rsp.done) state_d = full ? swlr_pkg::ST_D3 : swlr_pkg::ST_F3;
			swlr_pkg::ST_D3:   if (rsp.done) state_d = swlr_pkg::ST_AVGXY;
			swlr_pkg::ST_AVGXY: if (rsp.done) state_d = swlr_pkg::ST_AVGSQ;
			swlr_pkg::ST_AVGSQ: if (rsp.done) state_d = swlr_pkg::ST_CHK;
			swlr_pkg::ST_CHK: begin
				if (mxx_q != avsq_q) state_d = swlr_pkg::ST_BDIV;
				else if (mx_q != 0) state_d = swlr_pkg::ST_BZV;
				else state_d = swlr_pkg::ST_BQ;
			end
			swlr_pkg::ST_BZV:  if (rsp.done) state_d = swlr_pkg::ST_BQ;
			swlr_pkg::ST_BDIV: if (rsp.done) state_d = swlr_pkg::ST_BMX;
			swlr_pkg::ST_BMX:  if (rsp.done) state_d = swlr_pkg::ST_ADIV;
			swlr_pkg::ST_ADIV: if (rsp.done) state_d = swlr_pkg::ST_BQ;
			swlr_pkg::ST_BQ:   if (rsp.done) state_d = swlr_pkg::ST_OUT;
			swlr_pkg::ST_OUT:  if (out_valid && out_ready) state_d = swlr_pkg::ST_IDLE;
			default: state_d = swlr_pkg::ST_IDLE;
		endcase
	end

	// unit requests
	always_comb begin
		req.start = 1'b0;
		req.op = swlr_pkg::OP_MUL;
		req.a = '0;
		req.b = '0;
		unique case (state_q)
			swlr_pkg::ST_MXY: begin req.a = x_q; req.b = y_q; end
			swlr_pkg::ST_MXX: begin req.a = x_q; req.b = x_q; end
			swlr_pkg::ST_OXY: begin req.a = ox; req.b = oy; end
			swlr_pkg::ST_OXX: begin req.a = ox; req.b = ox; end
			swlr_pkg::ST_F0: begin req.a = mx_q; req.b = k; end
			swlr_pkg::ST_F1: begin req.a = my_q; req.b = k; end
			swlr_pkg::ST_F2: begin req.a = mxy_q; req.b = k; end
			swlr_pkg::ST_F3: begin req.a = mxx_q; req.b = k; end
			swlr_pkg::ST_D0: begin
				req.op = swlr_pkg::OP_DIV;
				req.a = full ? ox - x_q : t_q + x_q;
				req.b = full ? 64'(swlr_pkg::WindowSize) : k + 64'd1;
			end
			swlr_pkg::ST_D1: begin
				req.op = swlr_pkg::OP_DIV;
				req.a = full ? oy - y_q : t_q + y_q;
				req.b = full ? 64'(swlr_pkg::WindowSize) : k + 64'd1;
			end
			swlr_pkg::ST_D2: begin
				req.op = swlr_pkg::OP_DIV;
				req.a = full ? oxy_q - xy_q : t_q + xy_q;
				req.b = full ? 64'(swlr_pkg::WindowSize) : k + 64'd1;
			end
			swlr_pkg::ST_D3: begin
				req.op = swlr_pkg::OP_DIV;
				req.a = full ? oxx_q - xx_q : t_q + xx_q;
				req.b = full ? 64'(swlr_pkg::WindowSize) : k + 64'd1;
			end
			swlr_pkg::ST_AVGXY: begin req.a = mx_q; req.b = my_q; end
			swlr_pkg::ST_AVGSQ: begin req.a = mx_q; req.b = mx_q; end
			swlr_pkg::ST_BZV: begin req.op = swlr_pkg::OP_DIV; req.a = my_q; req.b = mx_q; end
			swlr_pkg::ST_BDIV: begin
				req.op = swlr_pkg::OP_DIV;
				req.a = mxy_q - avxy_q;
				req.b = mxx_q - avsq_q;
			end
			swlr_pkg::ST_BMX: begin req.a = b_q; req.b = mx_q; end
			swlr_pkg::ST_ADIV: begin
				req.op = swlr_pkg::OP_DIV;
				req.a = my_q - t_q;
				req.b = swlr_pkg::Scale;
			end
			swlr_pkg::ST_BQ: begin req.a = b_q; req.b = q_q; end
			default: ;
		endcase
		if (state_q != swlr_pkg::ST_IDLE && state_q != swlr_pkg::ST_CHK &&
		    state_q != swlr_pkg::ST_OUT) begin
			req.start = !issued_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swlr_pkg::ST_IDLE;
			issued_q <= 1'b0;
			out_valid <= 1'b0;
			slot_q <= '0;
			fill_q <= '0;
			mx_q <= '0;
			my_q <= '0;
			mxy_q <= '0;
			mxx_q <= '0;
			a_q <= '0;
			b_q <= '0;
		end else begin
			state_q <= state_d;
			if (req.start) issued_q <= 1'b1;
			else if (rsp.done) issued_q <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (ram_we) begin
				out_valid <= 1'b1;
				slot_q <= (slot_q == swlr_pkg::SlotW'(swlr_pkg::WindowSize - 1)) ?
					'0 : slot_q + 1'b1;
				if (!full) fill_q <= fill_q + 1'b1;
			end
			if (rsp.done) begin
				unique case (state_q)
					swlr_pkg::ST_D0: mx_q <= full ? mx_q - rsp.res : rsp.res;
					swlr_pkg::ST_D1: my_q <= full ? my_q - rsp.res : rsp.res;
					swlr_pkg::ST_D2: mxy_q <= full ? mxy_q - rsp.res : rsp.res;
					swlr_pkg::ST_D3: mxx_q <= full ? mxx_q - rsp.res : rsp.res;
					swlr_pkg::ST_BZV, swlr_pkg::ST_BDIV: b_q <= rsp.res;
					swlr_pkg::ST_ADIV: a_q <= rsp.res;
					default: ;
				endcase
			end
			if (state_q == swlr_pkg::ST_CHK && mxx_q == avsq_q) begin
				a_q <= '0;
				if (mx_q == 0) b_q <= 64'sd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q <= 64'(sample_x) * swlr_pkg::Scale;
			y_q <= 64'(sample_y) * swlr_pkg::Scale;
			q_q <= 64'(query_x);
		end
		if (rsp.done) begin
			unique case (state_q)
				swlr_pkg::ST_MXY: xy_q <= rsp.res;
				swlr_pkg::ST_MXX: xx_q <= rsp.res;
				swlr_pkg::ST_OXY: oxy_q <= rsp.res;
				swlr_pkg::ST_OXX: oxx_q <= rsp.res;
				swlr_pkg::ST_F0, swlr_pkg::ST_F1, swlr_pkg::ST_F2, swlr_pkg::ST_F3,
				swlr_pkg::ST_BMX: t_q <= rsp.res;
				swlr_pkg::ST_AVGXY: avxy_q <= rsp.res;
				swlr_pkg::ST_AVGSQ: avsq_q <= rsp.res;
				swlr_pkg::ST_BQ: prediction <= a_q + rsp.res;
				default: ;
			endcase
		end
	end

	assign intercept = a_q;
	assign slope = b_q;

endmodule

// File: hw/rtl/swlr_checker.sv
// Port-level checker for the regression unit, bound to the top level.
module swlr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [63:0] prediction,
	input logic signed [63:0] intercept,
	input logic signed [63:0] slope
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prediction) && $stable(slope))
		else $error("result changed while stalled");

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("not busy after transfer");

	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##2 !out_valid)
		else $error("result too early");

endmodule

bind sliding_window_linear_regression_unit swlr_checker u_swlr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .prediction(prediction),
	.intercept(intercept), .slope(slope)
);
